### hdl/rid_pkg.sv
// Shared types, constants and the control store for the radix digit converter.
package rid_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);
  localparam int IDX_W       = $clog2(VALUE_WIDTH);
  localparam int BIT_W       = $clog2(VALUE_WIDTH);

  localparam logic [7:0] DIGIT_BASE  = 8'd48;
  localparam logic [7:0] LETTER_BASE = 8'd55;
  localparam logic [3:0] DIGIT_MAX   = 4'd9;
  localparam logic [7:0] MINUS_CHAR  = 8'd45;

  localparam logic [4:0] RADIX_RESET = 5'd10;
  localparam logic [4:0] RADIX_MIN   = 5'd2;
  localparam logic [4:0] RADIX_MAX   = 5'd16;

  localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(VALUE_WIDTH - 1);

  // Microprogram step addresses
  typedef logic [2:0] step_t;
  localparam step_t S_IDLE     = 3'd0;
  localparam step_t S_DIV_INIT = 3'd1;
  localparam step_t S_DIV_STEP = 3'd2;
  localparam step_t S_STORE    = 3'd3;
  localparam step_t S_SIGN     = 3'd4;
  localparam step_t S_READ     = 3'd5;
  localparam step_t S_EMIT     = 3'd6;
  localparam step_t S_END      = 3'd7;

  // Jump conditions
  typedef logic [2:0] cond_t;
  localparam cond_t C_NONE        = 3'd0;
  localparam cond_t C_ALWAYS      = 3'd1;
  localparam cond_t C_NO_START    = 3'd2;
  localparam cond_t C_DIV_MORE    = 3'd3;
  localparam cond_t C_MAG_NZ      = 3'd4;
  localparam cond_t C_MORE_DIGITS = 3'd5;

  typedef struct packed {
    logic  load;
    logic  div_init;
    logic  div_step;
    logic  store;
    logic  emit_sign;
    logic  mem_read;
    logic  emit_digit;
    cond_t cond;
    step_t target;
  } ctl_t;

  typedef struct packed {
    logic start;
    logic div_more;
    logic mag_nz;
    logic more_digits;
  } status_t;

  function automatic ctl_t ucode(input step_t step);
    ctl_t w;
    w = '0;
    unique case (step)
      S_IDLE:     begin w.load = 1'b1;       w.cond = C_NO_START;    w.target = S_IDLE;     end
      S_DIV_INIT: begin w.div_init = 1'b1;   w.cond = C_NONE;        w.target = S_IDLE;     end
      S_DIV_STEP: begin w.div_step = 1'b1;   w.cond = C_DIV_MORE;    w.target = S_DIV_STEP; end
      S_STORE:    begin w.store = 1'b1;      w.cond = C_MAG_NZ;      w.target = S_DIV_INIT; end
      S_SIGN:     begin w.emit_sign = 1'b1;  w.cond = C_NONE;        w.target = S_IDLE;     end
      S_READ:     begin w.mem_read = 1'b1;   w.cond = C_NONE;        w.target = S_IDLE;     end
      S_EMIT:     begin w.emit_digit = 1'b1; w.cond = C_MORE_DIGITS; w.target = S_READ;     end
      S_END:      begin                      w.cond = C_ALWAYS;      w.target = S_IDLE;     end
      default:    begin                      w.cond = C_ALWAYS;      w.target = S_IDLE;     end
    endcase
    return w;
  endfunction

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    if (d <= DIGIT_MAX) begin
      return DIGIT_BASE + {4'd0, d};
    end
    return LETTER_BASE + {4'd0, d};
  endfunction

endpackage

### hdl/rid_useq.sv
// Microprogram sequencer: step counter, control store lookup and conditional jumps.
module rid_useq (
  input  logic             clk,
  input  logic             rst_n,
  input  rid_pkg::status_t status,
  output rid_pkg::ctl_t    ctl,
  output logic             busy
);
  import rid_pkg::*;

  step_t pc_r;
  step_t pc_nxt;
  logic  take;

  assign ctl  = ucode(pc_r);
  assign busy = (pc_r != S_IDLE);

  always_comb begin
    unique case (ctl.cond)
      C_NONE:        take = 1'b0;
      C_ALWAYS:      take = 1'b1;
      C_NO_START:    take = !status.start;
      C_DIV_MORE:    take = status.div_more;
      C_MAG_NZ:      take = status.mag_nz;
      C_MORE_DIGITS: take = status.more_digits;
      default:       take = 1'b1;
    endcase
    pc_nxt = take ? ctl.target : pc_r + step_t'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

### hdl/radix_integer_to_digits_top.sv
// Top level: signed integer to ASCII digits in a configurable radix.
// Sequence: per digit a division pass (init, then one quotient bit per cycle through the
//   shift-subtract divider, then store) until the quotient is zero; then a '-' for a
//   negative value, then each digit is read from the store and emitted, most significant
//   first. A new value is taken only once the sequencer is idle; receiver cannot stall.
// Reset (rst_n, synchronous, active low): sequencer to idle, radix to 10, strobe low.
module radix_integer_to_digits_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [rid_pkg::VALUE_WIDTH-1:0] in_value,
  input  logic                             cfg_wr_en,
  input  logic [4:0]                       cfg_wr_data,
  output logic                             out_valid,
  output logic [7:0]                       out_character,
  output logic                             out_last
);
  import rid_pkg::*;

  ctl_t    ctl;
  status_t status;

  // Configuration
  logic [4:0] radix_r;
  logic [4:0] base;

  // Datapath registers
  logic [VALUE_WIDTH-1:0] mag_r;      // magnitude, becomes the quotient each pass
  logic                   neg_r;
  logic [3:0]             rem_r;      // partial remainder, always below the base
  logic [BIT_W-1:0]       bit_r;      // quotient bit counter
  logic [CNT_W-1:0]       count_r;    // digits held in the store
  logic [3:0]             rd_data_r;

  // Digit store, least significant digit at index 0
  logic [3:0] digit_mem [VALUE_WIDTH];

  // Output registers
  logic       out_valid_r;
  logic [7:0] out_char_r;
  logic       out_last_r;

  logic [4:0] rem_shift;
  logic       rem_ge;
  logic [4:0] rem_sub;
  logic       do_load;
  logic [IDX_W-1:0] rd_idx;

  rid_useq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctl    (ctl),
    .busy   (busy)
  );

  // Out-of-range radix codes saturate to 2 and 16
  always_comb begin
    priority if (radix_r < RADIX_MIN) begin
      base = RADIX_MIN;
    end else if (radix_r > RADIX_MAX) begin
      base = RADIX_MAX;
    end else begin
      base = radix_r;
    end
  end

  // One restoring-division step: shift in the next dividend bit, subtract if it fits
  assign rem_shift = {rem_r, mag_r[VALUE_WIDTH-1]};
  assign rem_ge    = (rem_shift >= base);
  assign rem_sub   = rem_shift - base;

  assign do_load = ctl.load && start;
  assign rd_idx  = IDX_W'(count_r - CNT_W'(1));

  assign status.start       = start;
  assign status.div_more    = (bit_r != BIT_LAST);
  assign status.mag_nz      = (mag_r != '0);
  assign status.more_digits = (count_r != CNT_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (cfg_wr_en) begin
      radix_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (do_load) begin
      count_r <= '0;
    end else if (ctl.store) begin
      count_r <= count_r + CNT_W'(1);
    end else if (ctl.emit_digit) begin
      count_r <= count_r - CNT_W'(1);
    end
  end

  // Payload registers; the negation of the most negative value is its exact magnitude
  always_ff @(posedge clk) begin
    if (do_load) begin
      neg_r <= in_value[VALUE_WIDTH-1];
      mag_r <= in_value[VALUE_WIDTH-1] ? VALUE_WIDTH'(-in_value) : VALUE_WIDTH'(in_value);
    end else if (ctl.div_step) begin
      mag_r <= {mag_r[VALUE_WIDTH-2:0], rem_ge};
    end
    if (ctl.div_init) begin
      rem_r <= '0;
      bit_r <= '0;
    end else if (ctl.div_step) begin
      rem_r <= rem_ge ? rem_sub[3:0] : rem_shift[3:0];
      bit_r <= bit_r + BIT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.store) begin
      digit_mem[count_r[IDX_W-1:0]] <= rem_r;
    end
    if (ctl.mem_read) begin
      rd_data_r <= digit_mem[rd_idx];
    end
  end

  // Result strobe: '-' transfer for a negative value, then digits most significant first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (ctl.emit_sign && neg_r) || ctl.emit_digit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit_digit) begin
      out_char_r <= digit_char(rd_data_r);
      out_last_r <= !status.more_digits;
    end else begin
      out_char_r <= MINUS_CHAR;
      out_last_r <= 1'b0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

  // The run ends and the sequencer is idle in the cycle after the last transfer
  a_last_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !busy)
    else $error("sequencer not idle after last character");

  // Digit count stays within the store
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(VALUE_WIDTH))
    else $error("digit count beyond store depth");

  // An accepted value always makes the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted value did not start the sequencer");

  // A transfer only follows a busy cycle
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe while idle");

endmodule
